>>> src/b64e_pkg.sv
`timescale 1ns / 1ps
// Package for the base64 stream encoder: payload types, constants, alphabet lookup.
package b64e_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [7:0] PLUS_CHAR   = 8'h2B;
  localparam logic [7:0] SLASH_CHAR  = 8'h2F;
  localparam logic [7:0] UPPER_BASE  = 8'h41;
  localparam logic [7:0] LOWER_BASE  = 8'h47;  // 'a' - 26
  localparam logic [7:0] DIGIT_BASE  = 8'hFC;  // '0' - 52, modulo 256
  localparam logic [5:0] SEXTET_MASK = 6'h3F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } char_item_t;

  // one group of one to three bytes handed from front to back
  typedef struct packed {
    logic [23:0] grp;
    logic [1:0]  nbytes;
    logic        fin;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] idx);
    logic [7:0] w;
    w = {2'b00, idx & SEXTET_MASK};
    if (idx < 6'd26)      sextet_char = UPPER_BASE + w;
    else if (idx < 6'd52) sextet_char = LOWER_BASE + w;
    else if (idx < 6'd62) sextet_char = DIGIT_BASE + w;
    else if (idx == 6'd62) sextet_char = PLUS_CHAR;
    else                   sextet_char = SLASH_CHAR;
  endfunction

endpackage

>>> src/base64_stream_encoder_top.sv
`timescale 1ns / 1ps
// Top level of the base64 stream encoder.
//
//  channel   | direction | payload      | handshake
//  byte      | in        | byte_item_t  | byte_valid / byte_stall
//  char      | out       | char_item_t  | char_valid / char_stall
//
//  A byte is taken each cycle while the group queue has room; the back end
//  emits one character per cycle while char_stall is low, four per group.
//  With the back end idle, the group that a closing byte completes is
//  first written into the queue, then its first character is loaded
//  into the output register.
//  rst (synchronous) clears pending bytes, the queue and char_valid.
//  char_stall holds the output register; the two-entry queue absorbs the front.
module base64_stream_encoder_top import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_data,
  output logic       char_valid,
  input  logic       char_stall,
  output char_item_t char_data
);

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  group_t q_in;
  group_t q_head;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  b64e_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

endmodule

>>> src/b64e_front.sv
`timescale 1ns / 1ps
// Front end: holds pending bytes and builds zero-filled 24-bit groups.
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_data,
  input  logic       q_full,
  output logic       q_push,
  output group_t     q_data
);

  logic [15:0] pending_bytes;
  logic [1:0]  pending_count;
  logic [1:0]  count;
  logic        accept;

  assign count      = (pending_count == 2'd3) ? 2'd0 : pending_count;
  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;
  assign q_push     = accept && (byte_data.final_byte || count == 2'd2);

  always_comb begin
    q_data.fin = byte_data.final_byte;
    unique case (count)
      2'd0: begin
        q_data.grp    = {byte_data.data_byte, 16'h0000};
        q_data.nbytes = 2'd1;
      end
      2'd1: begin
        q_data.grp    = {pending_bytes[15:8], byte_data.data_byte, 8'h00};
        q_data.nbytes = 2'd2;
      end
      default: begin
        q_data.grp    = {pending_bytes, byte_data.data_byte};
        q_data.nbytes = 2'd3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      pending_bytes <= 16'h0000;
    end else if (accept) begin
      if (q_push) begin
        pending_count <= 2'd0;
        pending_bytes <= 16'h0000;
      end else if (count == 2'd0) begin
        pending_count <= 2'd1;
        pending_bytes <= {byte_data.data_byte, 8'h00};
      end else begin
        pending_count <= 2'd2;
        pending_bytes <= {pending_bytes[15:8], byte_data.data_byte};
      end
    end
  end

endmodule

>>> src/b64e_queue.sv
`timescale 1ns / 1ps
// Two-entry group queue between front and back ends.
module b64e_queue import b64e_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_data,
  input  logic   pop,
  output group_t head,
  output logic   full,
  output logic   empty
);

  group_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      priority if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

>>> src/b64e_back.sv
`timescale 1ns / 1ps
// Back end: serializes each group into four characters through an output register.
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  group_t     q_head,
  output logic       q_pop,
  output logic       char_valid,
  input  logic       char_stall,
  output char_item_t char_data
);

  group_t     cur;
  logic       busy;
  logic [1:0] idx;
  logic       advance;
  logic       emit;
  group_t     src;
  char_item_t emit_item;

  assign advance = !char_valid || !char_stall;
  assign emit    = advance && (busy || !q_empty);
  assign q_pop   = advance && !busy && !q_empty;
  assign src     = busy ? cur : q_head;

  always_comb begin
    emit_item.last_char = 1'b0;
    unique case (idx)
      2'd0: emit_item.out_char = sextet_char(src.grp[23:18]);
      2'd1: emit_item.out_char = sextet_char(src.grp[17:12]);
      2'd2: emit_item.out_char = (src.nbytes >= 2'd2) ? sextet_char(src.grp[11:6]) : PAD_CHAR;
      default: begin
        emit_item.out_char  = (src.nbytes == 2'd3) ? sextet_char(src.grp[5:0]) : PAD_CHAR;
        emit_item.last_char = src.fin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (emit) char_data <= emit_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= 2'd0;
      char_valid <= 1'b0;
    end else if (advance) begin
      char_valid <= emit;
      if (emit) begin
        idx  <= idx + 2'd1;
        busy <= (idx != 2'd3);
      end
    end
  end

endmodule

>>> src/b64e_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the base64 stream encoder, bound to the top level.
module b64e_checker import b64e_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input byte_item_t byte_data,
  input logic       char_valid,
  input logic       char_stall,
  input char_item_t char_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && byte_stall) |=> (byte_valid && $stable(byte_data)))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_stall) |=> (char_valid && $stable(char_data)))
    else $error("output transaction changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !char_valid)
    else $error("output valid after reset");

  a_double_pad: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall && char_data.out_char == PAD_CHAR && !char_data.last_char)
    |=> (char_valid && char_data.out_char == PAD_CHAR && char_data.last_char))
    else $error("third-position pad not followed by final pad");

endmodule

bind base64_stream_encoder_top b64e_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_data  (byte_data),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_data  (char_data)
);
